FILE: sv/ima_pkg.sv
// ----------------------------------------------------------------------------
// ima_pkg - integer matrix arithmetic shared definitions
// Widths, operation and mode codes, register indexes, the queued command
// and the helper functions used by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package ima_pkg;

   localparam int MAX_DIM     = 8;
   localparam int DATA_WIDTH  = 32;
   localparam int RES_W       = 32;
   localparam int IDX_W       = $clog2(MAX_DIM);
   localparam int ADDR_W      = 2 * IDX_W;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int DIM_W       = 4;
   localparam int MODE_W      = 2;
   localparam int OPER_W      = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // request operation codes
   localparam logic [OPER_W-1:0] OP_WRITE_A = 2'd0;
   localparam logic [OPER_W-1:0] OP_WRITE_B = 2'd1;
   localparam logic [OPER_W-1:0] OP_COMPUTE = 2'd2;

   // op_mode codes (bit 1 set selects the product)
   localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MUL = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROWS_A    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_DIM = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLS_B    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OP_MODE   = 3'd3;

   localparam logic [DIM_W-1:0]  DIM_RESET  = 4'd8;
   localparam logic [MODE_W-1:0] MODE_RESET = MODE_MUL;

   typedef enum logic [1:0] {
      KIND_WR_A,
      KIND_WR_B,
      KIND_COMPUTE
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [ADDR_W-1:0]     addr;
      logic [DATA_WIDTH-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic [DIM_W-1:0]  rows_a;
      logic [DIM_W-1:0]  inner_dim;
      logic [DIM_W-1:0]  cols_b;
      logic [MODE_W-1:0] op_mode;
   } cfg_type;

   // Highest index for a dimension register: zero counts as one, anything
   // above MAX_DIM counts as MAX_DIM.
   function automatic logic [IDX_W-1:0] last_index(input logic [DIM_W-1:0] dim);
      logic [DIM_W-1:0] lim;
      lim = DIM_W'(MAX_DIM);
      if (dim == '0)
         return '0;
      else if (dim > lim)
         return IDX_W'(MAX_DIM - 1);
      else
         return IDX_W'(dim - 4'd1);
   endfunction

   // Sign-extend a stored word to the result width.
   function automatic logic [RES_W-1:0] sext(input logic [DATA_WIDTH-1:0] v);
      logic signed [DATA_WIDTH-1:0] s;
      s = signed'(v);
      return RES_W'(s);
   endfunction

endpackage

FILE: sv/integer_matrix_arithmetic_top.sv
// ----------------------------------------------------------------------------
// integer_matrix_arithmetic_top - integer matrix add, subtract and multiply
// Loads matrices A and B element by element and emits A+B, A-B or AxB.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one request per handshake (valid high, stall low). Operation
//            0/1 writes value into A/B at (row, col); 2 emits the result
//            matrix in row-major order; 3 is accepted and dropped.
//   rsp_*  : one result element per handshake, with its row, column and a
//            last flag on the final element. Hold rsp_stall to pause it.
//   csr_*  : register writes (rows_a, inner_dim, cols_b, op_mode), always
//            ready; write only while no request is in flight.
// Timing:
//   A load passes through a queue entry and then into the engine, so loads
//   stream at one per cycle while the engine is idle. A compute request is
//   taken from the queue once the engine is idle; each result element sums
//   K terms, K = inner_dim for a product and 1 for add/subtract, through the
//   read/op/accumulate stages; each matrix store has a single read port.
//   Requests behind a compute wait in the 4-entry queue; req_stall rises
//   only when that queue is full. A stalled receiver freezes the engine
//   once the finished element cannot move to the output register.
// Reset: registers return to 8x8x8 multiply, queue and engine empty;
//   matrix contents stay undefined until written.
// ----------------------------------------------------------------------------
module integer_matrix_arithmetic_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [ima_pkg::OPER_W-1:0]            req_operation,
   input  logic [ima_pkg::IDX_W-1:0]             req_row_index,
   input  logic [ima_pkg::IDX_W-1:0]             req_col_index,
   input  logic signed [ima_pkg::RES_W-1:0]      req_value,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ima_pkg::IDX_W-1:0]             rsp_result_row,
   output logic [ima_pkg::IDX_W-1:0]             rsp_result_col,
   output logic signed [ima_pkg::RES_W-1:0]      rsp_result_value,
   output logic                                  rsp_last,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ima_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ima_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   ima_pkg::cfg_type cfg_ff, cfg_in;
   ima_pkg::cmd_type push_cmd, head_cmd;
   logic             q_push, q_pop, q_full, q_empty;

   // register file: writes always accepted, unknown indexes ignored
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            ima_pkg::REG_ROWS_A:    cfg_in.rows_a    = csr_wdata;
            ima_pkg::REG_INNER_DIM: cfg_in.inner_dim = csr_wdata;
            ima_pkg::REG_COLS_B:    cfg_in.cols_b    = csr_wdata;
            ima_pkg::REG_OP_MODE:   cfg_in.op_mode   = csr_wdata[ima_pkg::MODE_W-1:0];
            default:                cfg_in           = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows_a    <= ima_pkg::DIM_RESET;
         cfg_ff.inner_dim <= ima_pkg::DIM_RESET;
         cfg_ff.cols_b    <= ima_pkg::DIM_RESET;
         cfg_ff.op_mode   <= ima_pkg::MODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: decode requests into queued commands
   ima_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_value     (req_value),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (push_cmd)
   );

   // queue between decode and execution
   ima_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   // back: stores, compute pipeline and result register
   ima_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head_cmd         (head_cmd),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_row   (rsp_result_row),
      .rsp_result_col   (rsp_result_col),
      .rsp_result_value (rsp_result_value),
      .rsp_last         (rsp_last)
   );

endmodule

FILE: sv/ima_front.sv
// ----------------------------------------------------------------------------
// ima_front - request decode
// Classify each request into a command for the queue; drop unused codes.
// ----------------------------------------------------------------------------
module ima_front (
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ima_pkg::OPER_W-1:0]          req_operation,
   input  logic [ima_pkg::IDX_W-1:0]           req_row_index,
   input  logic [ima_pkg::IDX_W-1:0]           req_col_index,
   input  logic signed [ima_pkg::RES_W-1:0]    req_value,
   input  logic                                q_full,
   output logic                                q_push,
   output ima_pkg::cmd_type                    q_cmd
);

   logic accept;
   logic known;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      q_cmd.addr = {req_row_index, req_col_index};
      q_cmd.data = ima_pkg::DATA_WIDTH'(req_value);
      known      = 1'b1;
      case (req_operation)
         ima_pkg::OP_WRITE_A: q_cmd.kind = ima_pkg::KIND_WR_A;
         ima_pkg::OP_WRITE_B: q_cmd.kind = ima_pkg::KIND_WR_B;
         ima_pkg::OP_COMPUTE: q_cmd.kind = ima_pkg::KIND_COMPUTE;
         default: begin
            // unused operation: accept and drop
            q_cmd.kind = ima_pkg::KIND_COMPUTE;
            known      = 1'b0;
         end
      endcase
   end

   assign q_push = accept && known;

endmodule

FILE: sv/ima_queue.sv
// ----------------------------------------------------------------------------
// ima_queue - command queue
// Small FIFO that decouples request decode from execution.
// ----------------------------------------------------------------------------
module ima_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ima_pkg::cmd_type push_cmd,
   input  logic             pop,
   output ima_pkg::cmd_type head_cmd,
   output logic             full,
   output logic             empty
);

   ima_pkg::cmd_type                 entry_ff [ima_pkg::QUEUE_DEPTH];
   logic [ima_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ima_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ima_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full     = (count_ff == ima_pkg::QCNT_W'(ima_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

FILE: sv/ima_back.sv
// ----------------------------------------------------------------------------
// ima_back - matrix store and compute engine
// Hold both matrices, walk each result element through read, multiply, add
// or subtract, and accumulate stages, and drive the result output register.
// ----------------------------------------------------------------------------
module ima_back (
   input  logic                             clock,
   input  logic                             reset,
   input  ima_pkg::cfg_type                 cfg,
   input  ima_pkg::cmd_type                 head_cmd,
   input  logic                             q_empty,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ima_pkg::IDX_W-1:0]        rsp_result_row,
   output logic [ima_pkg::IDX_W-1:0]        rsp_result_col,
   output logic signed [ima_pkg::RES_W-1:0] rsp_result_value,
   output logic                             rsp_last
);

   localparam int IW = ima_pkg::IDX_W;
   localparam int DW = ima_pkg::DATA_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [IW-1:0]      r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic [IW-1:0]      nr_last_ff, nr_last_in;
   logic [IW-1:0]      nk_last_ff, nk_last_in;
   logic [IW-1:0]      nc_last_ff, nc_last_in;
   logic               mul_ff, mul_in, sub_ff, sub_in;

   logic [DW-1:0]      store_a [ima_pkg::STORE_DEPTH];
   logic [DW-1:0]      store_b [ima_pkg::STORE_DEPTH];
   logic [ima_pkg::ADDR_W-1:0] rd_addr_a, rd_addr_b;
   logic [DW-1:0]      rd_a_ff, rd_b_ff;

   logic               s1_valid_ff, s1_first_ff, s1_lastk_ff;
   logic               s2_valid_ff, s2_first_ff, s2_lastk_ff;
   logic [DW-1:0]      op_ff, op_in;
   logic [DW-1:0]      acc_ff, acc_in;
   logic               acc_done_ff, acc_done_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]      rsp_row_ff, rsp_col_ff;
   logic [ima_pkg::RES_W-1:0] rsp_value_ff;
   logic               rsp_last_ff;

   logic               wr_a, wr_b, start, issue, lastk, out_free, load, last_elem;

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign wr_a      = q_pop && (head_cmd.kind == ima_pkg::KIND_WR_A);
   assign wr_b      = q_pop && (head_cmd.kind == ima_pkg::KIND_WR_B);
   assign start     = q_pop && (head_cmd.kind == ima_pkg::KIND_COMPUTE);
   assign issue     = (state_ff == ST_WALK);
   assign lastk     = (k_ff == nk_last_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load      = (state_ff == ST_DRAIN) && acc_done_ff && out_free;
   assign last_elem = (r_ff == nr_last_ff) && (c_ff == nc_last_ff);

   // product walks A row against B column; add/sub reads the same cell of both
   assign rd_addr_a = {r_ff, mul_ff ? k_ff : c_ff};
   assign rd_addr_b = mul_ff ? {k_ff, c_ff} : {r_ff, c_ff};

   // sequencer
   always_comb begin
      state_in   = state_ff;
      r_in       = r_ff;
      c_in       = c_ff;
      k_in       = k_ff;
      nr_last_in = nr_last_ff;
      nk_last_in = nk_last_ff;
      nc_last_in = nc_last_ff;
      mul_in     = mul_ff;
      sub_in     = sub_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mul_in     = cfg.op_mode[1];
               sub_in     = (cfg.op_mode == ima_pkg::MODE_SUB);
               nr_last_in = ima_pkg::last_index(cfg.rows_a);
               nk_last_in = cfg.op_mode[1] ? ima_pkg::last_index(cfg.inner_dim) : '0;
               nc_last_in = cfg.op_mode[1] ? ima_pkg::last_index(cfg.cols_b)
                                           : ima_pkg::last_index(cfg.inner_dim);
               r_in       = '0;
               c_in       = '0;
               k_in       = '0;
               state_in   = ST_WALK;
            end
         end
         ST_WALK: begin
            if (lastk)
               state_in = ST_DRAIN;
            else
               k_in = k_ff + 1'b1;
         end
         ST_DRAIN: begin
            if (load) begin
               k_in = '0;
               if (last_elem) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_WALK;
                  if (c_ff == nc_last_ff) begin
                     c_in = '0;
                     r_in = r_ff + 1'b1;
                  end else begin
                     c_in = c_ff + 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      if (mul_ff)
         op_in = rd_a_ff * rd_b_ff;
      else if (sub_ff)
         op_in = rd_a_ff - rd_b_ff;
      else
         op_in = rd_a_ff + rd_b_ff;
      acc_in      = acc_ff;
      acc_done_in = acc_done_ff;
      if (s2_valid_ff) begin
         acc_in      = s2_first_ff ? op_ff : acc_ff + op_ff;
         acc_done_in = s2_lastk_ff;
      end else if (load) begin
         acc_done_in = 1'b0;
      end
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         acc_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         acc_done_ff  <= acc_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff        <= r_in;
      c_ff        <= c_in;
      k_ff        <= k_in;
      nr_last_ff  <= nr_last_in;
      nk_last_ff  <= nk_last_in;
      nc_last_ff  <= nc_last_in;
      mul_ff      <= mul_in;
      sub_ff      <= sub_in;
      s1_first_ff <= (k_ff == '0);
      s1_lastk_ff <= lastk;
      s2_first_ff <= s1_first_ff;
      s2_lastk_ff <= s1_lastk_ff;
      op_ff       <= op_in;
      acc_ff      <= acc_in;
      if (load) begin
         rsp_row_ff   <= r_ff;
         rsp_col_ff   <= c_ff;
         rsp_value_ff <= ima_pkg::sext(acc_ff);
         rsp_last_ff  <= last_elem;
      end
   end

   // matrix stores: one write and one registered read each per cycle
   always_ff @(posedge clock) begin
      if (wr_a)
         store_a[head_cmd.addr] <= head_cmd.data;
      rd_a_ff <= store_a[rd_addr_a];
   end

   always_ff @(posedge clock) begin
      if (wr_b)
         store_b[head_cmd.addr] <= head_cmd.data;
      rd_b_ff <= store_b[rd_addr_b];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_row   = rsp_row_ff;
   assign rsp_result_col   = rsp_col_ff;
   assign rsp_result_value = signed'(rsp_value_ff);
   assign rsp_last         = rsp_last_ff;

   a_pipe_empty_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!s1_valid_ff && !s2_valid_ff && !acc_done_ff))
      else $error("compute pipeline busy while idle");

   a_read_follows_walk: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $past(state_ff == ST_WALK))
      else $error("store read without walk step");

   a_no_stale_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> !acc_done_ff)
      else $error("finished sum left over during walk");

   a_load_only_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !load)
      else $error("output register overwritten while stalled");

endmodule
